### hdl/mvls_pkg.sv
package mvls_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CELL_W    = 3;
    localparam int GAIN_W    = 32;
    localparam int RAMP_W    = 8;
    localparam int MCAND_W   = GAIN_W + 1;
    localparam int HI_W      = MCAND_W + 1;
    localparam int PROD_W    = HI_W + SAMPLE_W;
    localparam int CNT_W     = 5;
    localparam int MUL_STEPS = SAMPLE_W;
    localparam int DIV_STEPS = GAIN_W;
    localparam int GAIN_FRAC = 30;

    localparam logic [SAMPLE_W-1:0] LEVEL_ONE = 16'h8000;

    typedef struct packed {
        logic [CELL_W-1:0]          cell_req;
        logic                       block_start;
        logic signed [SAMPLE_W-1:0] control_voltage;
        logic signed [SAMPLE_W-1:0] sample_in;
    } vca_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [CELL_W-1:0]          out_cell;
    } vca_out_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TMUL = 8'b0000_0010,
        S_TCMP = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_STEP = 8'b0001_0000,
        S_RAMP = 8'b0010_0000,
        S_SMUL = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } vca_state_t;

endpackage

### hdl/multichannel_vca_linear_slew.sv
// Multichannel VCA with a shared level and a linear gain slew per cell. Each transfer carries
// one Q1.15 sample for one cell; the result is the sample times the cell's Q2.30 gain, floored
// and saturated to 16 bits. One item is handled at a time. The products come from a bit-serial
// shift-add multiplier, and a bit-serial divider forms the ramp step when a retarget changes
// the target. A cell index at or above NUM_CELLS returns a zero sample and changes no state.
// The level register resets to 1.0, and a written value above 1.0 is clamped to 1.0.
module multichannel_vca_linear_slew
    import mvls_pkg::*;
#(
    parameter int NUM_CELLS    = 8,
    parameter int RAMP_SAMPLES = 88
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  vca_in_t             src_item,
    output logic                dst_valid,
    input  logic                dst_stall,
    output vca_out_t            dst_item,
    input  logic                level_we,
    input  logic [SAMPLE_W-1:0] level_wdata
);

    localparam int CIW      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int RAMP_LEN = (RAMP_SAMPLES < 1) ? 1 : ((RAMP_SAMPLES > 255) ? 255 : RAMP_SAMPLES);
    localparam logic [RAMP_W-1:0] RAMP_INIT = RAMP_W'(RAMP_LEN);
    localparam logic [RAMP_W:0]   DIVISOR   = (RAMP_W + 1)'(RAMP_LEN);

    vca_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [SAMPLE_W-1:0] level_reg;

    logic [CELL_W-1:0]          cell_reg, cell_next;
    logic                       in_range_reg, in_range_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    logic [HI_W-1:0]     hi_reg, hi_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [MCAND_W-1:0]  mcand_reg, mcand_next;

    logic [GAIN_W-1:0] dvd_reg, dvd_next;
    logic [RAMP_W-1:0] rem_reg, rem_next;
    logic              neg_reg, neg_next;

    logic     dst_valid_reg, dst_valid_next;
    vca_out_t dst_item_reg, dst_item_next;

    logic signed [GAIN_W-1:0] gain_now_reg    [0:NUM_CELLS-1];
    logic signed [GAIN_W-1:0] gain_target_reg [0:NUM_CELLS-1];
    logic signed [GAIN_W-1:0] gain_step_reg   [0:NUM_CELLS-1];
    logic [RAMP_W-1:0]        ramp_left_reg   [0:NUM_CELLS-1];

    logic                     now_we, target_we, step_we, left_we;
    logic signed [GAIN_W-1:0] now_wdata, target_wdata, step_wdata;
    logic [RAMP_W-1:0]        left_wdata;

    logic [CIW-1:0]           idx;
    logic signed [GAIN_W-1:0] cur_now, cur_target, cur_step;
    logic [RAMP_W-1:0]        cur_left;

    logic              mul_last;
    logic [HI_W-1:0]   mcand_ext, addend, sum;
    logic [PROD_W-1:0] prod;
    logic signed [GAIN_W-1:0] tgt, gain_use;
    logic signed [GAIN_W:0]   diff;
    logic [GAIN_W:0]          diff_mag;
    logic [RAMP_W:0]          trial;
    logic                     trial_ge;
    logic [PROD_W-GAIN_FRAC-1:0] y;
    logic signed [SAMPLE_W-1:0]  y_sat;
    logic                        out_load;

    always_comb
    begin
        idx        = CIW'(cell_reg);
        cur_now    = gain_now_reg[idx];
        cur_target = gain_target_reg[idx];
        cur_step   = gain_step_reg[idx];
        cur_left   = ramp_left_reg[idx];

        mul_last  = (cnt_reg == CNT_W'(MUL_STEPS - 1));
        mcand_ext = {mcand_reg[MCAND_W-1], mcand_reg};
        if (!lo_reg[0])
        begin
            addend = '0;
        end
        else if (mul_last)
        begin
            addend = -mcand_ext;
        end
        else
        begin
            addend = mcand_ext;
        end
        sum  = hi_reg + addend;
        prod = {hi_reg, lo_reg};
        tgt  = prod[GAIN_W-1:0];

        diff     = {tgt[GAIN_W-1], tgt} - {cur_now[GAIN_W-1], cur_now};
        diff_mag = diff[GAIN_W] ? -diff : diff;

        trial    = {rem_reg, dvd_reg[GAIN_W-1]};
        trial_ge = (trial >= DIVISOR);

        if (cur_left == RAMP_W'(1))
        begin
            gain_use = cur_target;
        end
        else if (cur_left != '0)
        begin
            gain_use = cur_now + cur_step;
        end
        else
        begin
            gain_use = cur_now;
        end

        y = prod[PROD_W-1:GAIN_FRAC];
        if (y[PROD_W-GAIN_FRAC-1:SAMPLE_W-1] == '0 || y[PROD_W-GAIN_FRAC-1:SAMPLE_W-1] == '1)
        begin
            y_sat = y[SAMPLE_W-1:0];
        end
        else if (y[PROD_W-GAIN_FRAC-1])
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = 16'sh7fff;
        end
    end

    assign out_load = (state_reg == S_FIN) && (!dst_valid_reg || !dst_stall);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + CNT_W'(1);
        cell_next      = cell_reg;
        in_range_next  = in_range_reg;
        sample_next    = sample_reg;
        hi_next        = {sum[HI_W-1], sum[HI_W-1:1]};
        lo_next        = {sum[0], lo_reg[SAMPLE_W-1:1]};
        mcand_next     = mcand_reg;
        dvd_next       = {dvd_reg[GAIN_W-2:0], trial_ge};
        rem_next       = trial_ge ? RAMP_W'(trial - DIVISOR) : trial[RAMP_W-1:0];
        neg_next       = neg_reg;
        dst_valid_next = dst_valid_reg && dst_stall;
        dst_item_next  = dst_item_reg;

        now_we       = 1'b0;
        target_we    = 1'b0;
        step_we      = 1'b0;
        left_we      = 1'b0;
        now_wdata    = gain_use;
        target_wdata = tgt;
        step_wdata   = neg_reg ? -dvd_reg : dvd_reg;
        left_wdata   = RAMP_INIT;

        case (state_reg)
            S_IDLE:
            begin
                hi_next    = hi_reg;
                lo_next    = lo_reg;
                dvd_next   = dvd_reg;
                rem_next   = rem_reg;
                if (src_valid)
                begin
                    cell_next     = src_item.cell_req;
                    sample_next   = src_item.sample_in;
                    in_range_next = ((CNT_W)'(src_item.cell_req) < CNT_W'(NUM_CELLS));
                    cnt_next      = '0;
                    hi_next       = '0;
                    lo_next       = src_item.control_voltage;
                    mcand_next    = MCAND_W'(level_reg);
                    if (!((CNT_W)'(src_item.cell_req) < CNT_W'(NUM_CELLS)))
                    begin
                        state_next = S_FIN;
                    end
                    else if (src_item.block_start)
                    begin
                        state_next = S_TMUL;
                    end
                    else
                    begin
                        state_next = S_RAMP;
                    end
                end
            end
            S_TMUL:
            begin
                if (mul_last)
                begin
                    state_next = S_TCMP;
                end
            end
            S_TCMP:
            begin
                hi_next  = hi_reg;
                lo_next  = lo_reg;
                cnt_next = '0;
                dvd_next = diff_mag[GAIN_W-1:0];
                rem_next = '0;
                neg_next = diff[GAIN_W];
                if (tgt != cur_target)
                begin
                    target_we  = 1'b1;
                    left_we    = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_RAMP;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                dvd_next   = dvd_reg;
                rem_next   = rem_reg;
                step_we    = 1'b1;
                state_next = S_RAMP;
            end
            S_RAMP:
            begin
                if (cur_left != '0)
                begin
                    now_we     = 1'b1;
                    left_we    = 1'b1;
                    left_wdata = cur_left - RAMP_W'(1);
                end
                cnt_next   = '0;
                hi_next    = '0;
                lo_next    = sample_reg;
                mcand_next = {gain_use[GAIN_W-1], gain_use};
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                if (mul_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                hi_next = hi_reg;
                lo_next = lo_reg;
                if (out_load)
                begin
                    dst_valid_next         = 1'b1;
                    dst_item_next.out_cell = cell_reg;
                    dst_item_next.sample_out = in_range_reg ? y_sat : '0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dst_valid_reg <= 1'b0;
            level_reg     <= LEVEL_ONE;
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                gain_now_reg[i]    <= '0;
                gain_target_reg[i] <= '0;
                gain_step_reg[i]   <= '0;
                ramp_left_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dst_valid_reg <= dst_valid_next;
            if (level_we)
            begin
                level_reg <= (level_wdata > LEVEL_ONE) ? LEVEL_ONE : level_wdata;
            end
            if (now_we)
            begin
                gain_now_reg[idx] <= now_wdata;
            end
            if (target_we)
            begin
                gain_target_reg[idx] <= target_wdata;
            end
            if (step_we)
            begin
                gain_step_reg[idx] <= step_wdata;
            end
            if (left_we)
            begin
                ramp_left_reg[idx] <= left_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg     <= cell_next;
        in_range_reg <= in_range_next;
        sample_reg   <= sample_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        mcand_reg    <= mcand_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        dst_item_reg <= dst_item_next;
    end

    assign src_stall = (state_reg != S_IDLE);
    assign dst_valid = dst_valid_reg;
    assign dst_item  = dst_item_reg;

`ifndef SYNTHESIS
    // A transfer on the input always starts work on the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> state_reg != S_IDLE)
        else $error("input transfer did not start processing");

    // A new result appears only when the final step of an item completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final step");

    // The ramp counter of an addressed cell never exceeds the ramp length.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RAMP && in_range_reg |-> cur_left <= RAMP_INIT)
        else $error("ramp counter out of range");

    // The ramp step is written only right after a full divider pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> $past(state_reg == S_DIV)
            && $past(cnt_reg == CNT_W'(DIV_STEPS - 1)))
        else $error("ramp step written without a full division");
`endif

endmodule

### bench/tb_multichannel_vca_linear_slew.sv
`timescale 1ns / 1ps

module tb_multichannel_vca_linear_slew;
    import mvls_pkg::*;

    localparam int NUM_CELLS    = 8;
    localparam int RAMP_SAMPLES = 88;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_PHASES   = 5;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        vca_in_t                    item;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] want;
    } directed_row_t;

    logic                clk;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    vca_in_t             src_item;
    logic                dst_valid;
    logic                dst_stall;
    vca_out_t            dst_item;
    logic                level_we;
    logic [SAMPLE_W-1:0] level_wdata;

    logic [SAMPLE_W-1:0]      model_level;
    logic signed [GAIN_W-1:0] model_gain [NUM_CELLS];
    logic signed [GAIN_W-1:0] model_target [NUM_CELLS];
    logic signed [GAIN_W-1:0] model_step [NUM_CELLS];
    logic [RAMP_W-1:0]        model_ramp_left [NUM_CELLS];

    logic signed [SAMPLE_W-1:0] last_cv [NUM_CELLS];
    vca_out_t                   pending_samples [$];
    directed_row_t              directed_rows [$];

    int  errors;
    int  items_sent;
    int  samples_checked;
    int  level_writes;
    int  retargets;
    int  idle_cycles;
    bit  src_quiet;
    bit  sink_quiet;
    int  stall_left;

    multichannel_vca_linear_slew #(
        .NUM_CELLS    (NUM_CELLS),
        .RAMP_SAMPLES (RAMP_SAMPLES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_item    (src_item),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_item    (dst_item),
        .level_we    (level_we),
        .level_wdata (level_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [GAIN_W-1:0] clamp_gain(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[GAIN_W-1:0];
    endfunction

    function automatic void reset_vca_model();
        model_level = LEVEL_ONE;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            model_gain[i]      = '0;
            model_target[i]    = '0;
            model_step[i]      = '0;
            model_ramp_left[i] = '0;
            last_cv[i]         = '0;
        end
    endfunction

    function automatic vca_out_t predict_vca_sample(vca_in_t it);
        vca_out_t                 r;
        int                       c;
        longint                   n;
        longint                   y;
        logic signed [GAIN_W-1:0] new_tgt;
        r.out_cell   = it.cell_req;
        r.sample_out = '0;
        c = int'(it.cell_req);
        if (c >= NUM_CELLS)
        begin
            return r;
        end
        if (it.block_start)
        begin
            new_tgt = clamp_gain(longint'($signed(it.control_voltage)) * longint'(model_level));
            if (new_tgt != model_target[c])
            begin
                n = (RAMP_SAMPLES < 1) ? 1 : ((RAMP_SAMPLES > 255) ? 255 : RAMP_SAMPLES);
                model_target[c]    = new_tgt;
                model_ramp_left[c] = n[RAMP_W-1:0];
                model_step[c]      = clamp_gain((longint'(new_tgt) - longint'(model_gain[c])) / n);
                retargets++;
            end
        end
        if (model_ramp_left[c] != 0)
        begin
            model_gain[c]      = clamp_gain(longint'(model_gain[c]) + longint'(model_step[c]));
            model_ramp_left[c] = model_ramp_left[c] - 1'b1;
            if (model_ramp_left[c] == 0)
            begin
                model_gain[c] = model_target[c];
            end
        end
        y = (longint'($signed(it.sample_in)) * longint'(model_gain[c])) >>> GAIN_FRAC;
        if (y > 32767)
        begin
            y = 32767;
        end
        else if (y < -32768)
        begin
            y = -32768;
        end
        r.sample_out = y[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 45)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        if ($urandom_range(0, 4) != 0)
        begin
            return SAMPLE_W'($urandom());
        end
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic vca_in_t make_item(int cell_idx, bit start);
        vca_in_t it;
        it.cell_req        = cell_idx[CELL_W-1:0];
        it.block_start     = start;
        it.control_voltage = SAMPLE_W'($urandom());
        it.sample_in       = pick_value();
        if (start)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                it.control_voltage = last_cv[cell_idx];
            end
            else
            begin
                it.control_voltage = pick_value();
            end
            last_cv[cell_idx] = it.control_voltage;
        end
        return it;
    endfunction

    task automatic add_row(int cell_idx, bit start, int cv, int smp, bit typed, int want);
        directed_row_t row;
        row.item.cell_req        = cell_idx[CELL_W-1:0];
        row.item.block_start     = start;
        row.item.control_voltage = cv[SAMPLE_W-1:0];
        row.item.sample_in       = smp[SAMPLE_W-1:0];
        row.typed                = typed;
        row.want                 = want[SAMPLE_W-1:0];
        directed_rows.push_back(row);
    endtask

    // Valid is lowered only when a gap follows, so back-to-back transfers keep it high.
    task automatic send_item(vca_in_t it, bit typed, logic signed [SAMPLE_W-1:0] want);
        int       gap;
        vca_out_t exp;
        gap = pick_gap(src_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (src_stall);
        exp = predict_vca_sample(it);
        if (typed)
        begin
            exp.sample_out = want;
        end
        pending_samples.push_back(exp);
        items_sent++;
    endtask

    task automatic source_idle();
        @(negedge clk);
        src_valid <= 1'b0;
    endtask

    task automatic write_level(logic [SAMPLE_W-1:0] value);
        source_idle();
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        level_we    <= 1'b1;
        level_wdata <= value;
        model_level = (value > LEVEL_ONE) ? LEVEL_ONE : value;
        level_writes++;
        @(negedge clk);
        level_we <= 1'b0;
    endtask

    task automatic run_random_phase(int wanted);
        int      done;
        int      cell_idx;
        int      len;
        vca_in_t it;
        done = 0;
        while (done < wanted)
        begin
            cell_idx  = $urandom_range(0, NUM_CELLS - 1);
            len       = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 110)
                                                     : $urandom_range(1, 12);
            src_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && done < wanted; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    it = make_item($urandom_range(0, NUM_CELLS - 1), $urandom_range(0, 3) == 0);
                end
                else if (k == 0)
                begin
                    it = make_item(cell_idx, $urandom_range(0, 3) != 0);
                end
                else
                begin
                    it = make_item(cell_idx, $urandom_range(0, 49) == 0);
                end
                send_item(it, 1'b0, '0);
                done++;
            end
        end
    endtask

    initial
    begin
        dst_stall  = 1'b0;
        stall_left = 0;
        sink_quiet = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
            begin
                sink_quiet = !sink_quiet;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dst_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap(sink_quiet);
                dst_stall <= (stall_left > 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        vca_out_t exp;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result cell=%0d sample=%0d", $time,
                         dst_item.out_cell, dst_item.sample_out);
            end
            else
            begin
                exp = pending_samples.pop_front();
                samples_checked++;
                if (dst_item.sample_out !== exp.sample_out)
                begin
                    errors++;
                    $display("%0t: sample_out expected %0d actual %0d (cell %0d)", $time,
                             exp.sample_out, dst_item.sample_out, exp.out_cell);
                end
                if (dst_item.out_cell !== exp.out_cell)
                begin
                    errors++;
                    $display("%0t: out_cell expected %0d actual %0d", $time,
                             exp.out_cell, dst_item.out_cell);
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || level_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("multichannel_vca_linear_slew verification failed");
        $finish;
    end

    initial
    begin
        logic [SAMPLE_W-1:0] lvl;
        clk             = 1'b0;
        rst_n           = 1'b0;
        src_valid       = 1'b0;
        src_item        = '0;
        level_we        = 1'b0;
        level_wdata     = '0;
        src_quiet       = 1'b0;
        errors          = 0;
        items_sent      = 0;
        samples_checked = 0;
        level_writes    = 0;
        retargets       = 0;
        reset_vca_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(0, 1'b0,      0,  32767, 1'b1, 0);
        add_row(7, 1'b0,      0, -32768, 1'b1, 0);
        add_row(1, 1'b1,      0,  32767, 1'b1, 0);
        add_row(2, 1'b1,  32767,  32767, 1'b0, 0);
        add_row(2, 1'b0,      0, -32768, 1'b0, 0);
        add_row(3, 1'b1, -32768,  32767, 1'b0, 0);
        add_row(3, 1'b0,      0, -32768, 1'b0, 0);
        add_row(2, 1'b1,  32767,  16384, 1'b0, 0);
        add_row(3, 1'b1,  16384,     -1, 1'b0, 0);
        add_row(4, 1'b1,     -1,     -1, 1'b0, 0);
        add_row(5, 1'b1,  32767,      0, 1'b1, 0);
        add_row(6, 1'b1,      1,      1, 1'b0, 0);
        add_row(0, 1'b1, -32768, -32768, 1'b0, 0);
        add_row(0, 1'b0,      0,  32767, 1'b0, 0);
        add_row(1, 1'b1,  21845,  12345, 1'b0, 0);
        add_row(1, 1'b1,      0,  12345, 1'b0, 0);
        add_row(7, 1'b1,  32767,  32767, 1'b0, 0);
        add_row(7, 1'b1,  32767, -32768, 1'b0, 0);
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       lvl = 16'h0000;
                1:       lvl = 16'hFFFF;
                2:       lvl = SAMPLE_W'($urandom_range(1, 32767));
                3:       lvl = 16'h8001;
                default: lvl = LEVEL_ONE;
            endcase
            write_level(lvl);
            run_random_phase(PHASE_ITEMS);
        end

        source_idle();
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples across %0d cells with %0d gain retargets.",
                 items_sent, NUM_CELLS, retargets);
        $display("Checked %0d results under %0d level settings plus the reset level.",
                 samples_checked, level_writes);
        if (errors == 0 && pending_samples.size() == 0)
        begin
            $display("multichannel_vca_linear_slew verification clean");
        end
        else
        begin
            $display("multichannel_vca_linear_slew verification failed");
        end
        $finish;
    end

endmodule
